[rtl/tcws_pkg.sv]
// Package for the text comment and whitespace stripper.
// Holds the mode enum, character codes, beat structs and the blank test.
// No dependencies; every source file but tcws_channels imports it.
`default_nettype none

package tcws_pkg;

  // Parser mode, one code per context of the text stream
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_BLANK  = 3'd1,
    MODE_SLASH  = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_STAR   = 3'd5,
    MODE_DQ     = 3'd6,
    MODE_SQ     = 3'd7
  } mode_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [1:0] out_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } result_t;

  // Input stage to core: the held beat and whether it moves on this cycle
  typedef struct packed {
    logic  fire;
    item_t item;
  } stage_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

[rtl/tcws_channels.sv]
// Valid/ready channel interfaces for the stripper's input and result beats.
// Depends on nothing; the payload widths follow the byte stream.
`default_nettype none

interface tcws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface tcws_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, out_count, first_byte, second_byte, input ready);
  modport sink   (input valid, out_count, first_byte, second_byte, output ready);
endinterface

`default_nettype wire

[rtl/tcws_in_reg.sv]
// Input register of the stripper: captures one beat and hands it on.
// Depends on tcws_pkg for item_t and stage_t.
`default_nettype none

module tcws_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tcws_pkg::item_t in_item,
  input  wire logic            take,
  output tcws_pkg::stage_t     stg
);
  import tcws_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  fire;

  // Advance the held beat whenever the result register can load
  assign fire     = valid_r && take;
  assign in_ready = !valid_r || take;

  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stg.fire = fire;
  assign stg.item = item_r;

endmodule

`default_nettype wire

[rtl/tcws_core.sv]
// Mode register and per-byte decision logic of the stripper.
// Depends on tcws_pkg for mode_t, the character codes and the beat structs.
`default_nettype none

module tcws_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tcws_pkg::stage_t stg,
  output tcws_pkg::result_t     res
);
  import tcws_pkg::*;

  mode_t      mode_r;
  mode_t      mode_nxt;
  mode_t      cur;
  logic [7:0] c;

  assign c   = stg.item.data_byte;
  // Restart forces normal mode before the byte is looked at
  assign cur = stg.item.restart ? MODE_NORMAL : mode_r;

  // Next mode
  always_comb begin
    mode_nxt = cur;
    case (cur)
      MODE_NORMAL, MODE_BLANK: begin
        if (is_blank(c)) begin
          mode_nxt = MODE_BLANK;
        end else if (c == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (c == CH_DQUOTE) begin
          mode_nxt = MODE_DQ;
        end else if (c == CH_SQUOTE) begin
          mode_nxt = MODE_SQ;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (c == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (c == CH_CR || c == CH_LF) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) begin
          mode_nxt = MODE_STAR;
        end
      end
      MODE_STAR: begin
        // a run of stars stays here until the closing slash
        if (c == CH_SLASH) begin
          mode_nxt = MODE_NORMAL;
        end else if (c != CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end
      end
      MODE_DQ: begin
        if (c == CH_DQUOTE) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_SQ: begin
        if (c == CH_SQUOTE) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: mode_nxt = MODE_NORMAL;
    endcase
  end

  // Emitted bytes
  always_comb begin
    res.out_count   = CNT_NONE;
    res.first_byte  = 8'h00;
    res.second_byte = 8'h00;
    case (cur)
      MODE_NORMAL: begin
        if (is_blank(c)) begin
          res.out_count  = CNT_ONE;
          res.first_byte = CH_SPACE;
        end else if (c != CH_SLASH) begin
          res.out_count  = CNT_ONE;
          res.first_byte = c;
        end
      end
      MODE_BLANK: begin
        // further blanks are dropped
        if (!is_blank(c) && c != CH_SLASH) begin
          res.out_count  = CNT_ONE;
          res.first_byte = c;
        end
      end
      MODE_SLASH: begin
        // a lone slash goes out with the byte after it
        if (c != CH_SLASH && c != CH_STAR) begin
          res.out_count   = CNT_TWO;
          res.first_byte  = CH_SLASH;
          res.second_byte = c;
        end
      end
      MODE_DQ, MODE_SQ: begin
        res.out_count  = CNT_ONE;
        res.first_byte = c;
      end
      MODE_LINE, MODE_BLOCK, MODE_STAR: begin
        res.out_count = CNT_NONE;
      end
      default: res.out_count = CNT_NONE;
    endcase
  end

  // Hold mode unless a beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (stg.fire) begin
      mode_r <= mode_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Two bytes only ever come from a held slash
  a_two_from_slash: assert property (@(posedge clk) disable iff (!rst_n)
    (stg.fire && res.out_count == CNT_TWO) |->
      (mode_r == MODE_SLASH && !stg.item.restart))
    else $error("two-byte result without a held slash");

  // Comment modes emit nothing unless restarted
  a_comment_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stg.fire && !stg.item.restart &&
     (mode_r == MODE_LINE || mode_r == MODE_BLOCK || mode_r == MODE_STAR))
      |-> (res.out_count == CNT_NONE))
    else $error("byte emitted inside a comment");

  // A line end closes a line comment
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (stg.fire && !stg.item.restart && mode_r == MODE_LINE &&
     (c == CH_CR || c == CH_LF)) |=> (mode_r == MODE_NORMAL))
    else $error("line comment not closed by line end");

  // Mode holds while no beat moves
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stg.fire |=> $stable(mode_r))
    else $error("mode changed without a beat");
`endif

endmodule

`default_nettype wire

[rtl/tcws_out_reg.sv]
// Result register of the stripper: holds one result beat until taken.
// Depends on tcws_pkg for result_t.
`default_nettype none

module tcws_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tcws_pkg::result_t res,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcws_pkg::result_t      out_res
);
  import tcws_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Free to load when empty or when the current beat leaves
  assign take      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

[rtl/text_comment_whitespace_stripper.sv]
// Top level of the text comment and whitespace stripper.
// Depends on tcws_pkg, tcws_channels, tcws_in_reg, tcws_core and tcws_out_reg.
//
//   channel | dir | payload                                  | beat
//   in_ch   | in  | data_byte[7:0], restart                  | one raw byte
//   out_ch  | out | out_count[1:0], first_byte, second_byte  | one result per byte
//
// One byte per cycle sustained while out_ch.ready holds; an accepted byte passes
// through the input register, then the result register, which presents its result
// until it is taken.
// The mode register updates when a beat moves into the result register.
// Synchronous active-low reset clears the valid flags and sets normal mode.
// A stalled result holds a full input register and keeps in_ch.ready low.
`default_nettype none

module text_comment_whitespace_stripper (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcws_in_if.sink     in_ch,
  tcws_out_if.source  out_ch
);
  import tcws_pkg::*;

  item_t   in_item;
  stage_t  stg;
  result_t res;
  result_t out_res;
  logic    take;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.restart   = in_ch.restart;

  tcws_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .take     (take),
    .stg      (stg)
  );

  tcws_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .stg   (stg),
    .res   (res)
  );

  tcws_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stg.fire),
    .res       (res),
    .take      (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.out_count   = out_res.out_count;
  assign out_ch.first_byte  = out_res.first_byte;
  assign out_ch.second_byte = out_res.second_byte;

endmodule

`default_nettype wire

[verif/tb_text_comment_whitespace_stripper.sv]
// Self-checking bench for text_comment_whitespace_stripper: directed text, then random fragments.
// A scoreboard class tracks the parser mode and queues one expected result per accepted byte.
// Depends on tcws_pkg, the tcws_channels interfaces and the stripper RTL.
`timescale 1ns / 100ps

module tb_text_comment_whitespace_stripper;
  import tcws_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 900;

  // Opening text: blank run, held slash cases, both comment kinds, both quote kinds, restart
  localparam logic [8:0] OPENING [27] = '{
    {1'b1, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, 8'h00},
    {1'b0, CH_SLASH}, {1'b0, 8'hFF},
    {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h6B}, {1'b0, CH_STAR}, {1'b0, CH_CR},
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
    {1'b0, CH_DQUOTE}, {1'b0, CH_SLASH}, {1'b0, CH_DQUOTE},
    {1'b0, CH_SQUOTE}, {1'b0, CH_TAB}, {1'b0, CH_SQUOTE},
    {1'b0, CH_SLASH}, {1'b0, CH_DQUOTE},
    {1'b0, CH_SLASH}, {1'b1, 8'h78}
  };

  // Mode tracker and queue of results owed by the block
  class strip_ledger;
    mode_t   mode;
    result_t owed[$];
    int      errors;

    function new();
      mode   = MODE_NORMAL;
      errors = 0;
    endfunction

    // Work out what one byte emits and advance the mode
    function result_t strip_byte(logic [7:0] c, logic restart);
      result_t r;
      mode_t   m;
      logic    blank;
      r     = '0;
      m     = restart ? MODE_NORMAL : mode;
      blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
      case (m)
        MODE_NORMAL, MODE_BLANK: begin
          if (blank) begin
            if (m == MODE_NORMAL) begin
              r.out_count  = CNT_ONE;
              r.first_byte = CH_SPACE;
              m            = MODE_BLANK;
            end
          end else if (c == CH_SLASH) begin
            m = MODE_SLASH;
          end else begin
            r.out_count  = CNT_ONE;
            r.first_byte = c;
            if (c == CH_DQUOTE) m = MODE_DQ;
            else if (c == CH_SQUOTE) m = MODE_SQ;
            else m = MODE_NORMAL;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            m = MODE_LINE;
          end else if (c == CH_STAR) begin
            m = MODE_BLOCK;
          end else begin
            r.out_count   = CNT_TWO;
            r.first_byte  = CH_SLASH;
            r.second_byte = c;
            m             = MODE_NORMAL;
          end
        end
        MODE_LINE: begin
          if (c == CH_CR || c == CH_LF) m = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) m = MODE_STAR;
        end
        MODE_STAR: begin
          if (c == CH_SLASH) m = MODE_NORMAL;
          else if (c != CH_STAR) m = MODE_BLOCK;
        end
        MODE_DQ: begin
          r.out_count  = CNT_ONE;
          r.first_byte = c;
          if (c == CH_DQUOTE) m = MODE_NORMAL;
        end
        MODE_SQ: begin
          r.out_count  = CNT_ONE;
          r.first_byte = c;
          if (c == CH_SQUOTE) m = MODE_NORMAL;
        end
        default: m = MODE_NORMAL;
      endcase
      mode = m;
      return r;
    endfunction

    function void note_byte(logic [7:0] c, logic restart);
      owed.push_back(strip_byte(c, restart));
    endfunction

    function void check_emit(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, count %0d first %h second %h",
                 $time, got.out_count, got.first_byte, got.second_byte);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_count !== want.out_count) begin
        $display("%0t: out_count expected %0d got %0d", $time, want.out_count, got.out_count);
        errors++;
      end
      if (got.first_byte !== want.first_byte) begin
        $display("%0t: first_byte expected %h got %h", $time, want.first_byte, got.first_byte);
        errors++;
      end
      if (got.second_byte !== want.second_byte) begin
        $display("%0t: second_byte expected %h got %h", $time, want.second_byte,
                 got.second_byte);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   bytes_sent;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_left;

  strip_ledger ledger = new();

  tcws_in_if  in_ch ();
  tcws_out_if out_ch ();

  text_comment_whitespace_stripper DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Give up at the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check each beat, then stall at random or hold off for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        ledger.check_emit({out_ch.out_count, out_ch.first_byte, out_ch.second_byte});
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one byte after any random idle cycles; hold it until accepted
  task automatic send_byte(input logic [7:0] c, input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= c;
    in_ch.restart   <= restart;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_byte(c, restart);
    bytes_sent++;
  endtask

  // Random text byte with an occasional restart
  task automatic send_text(input logic [7:0] c);
    send_byte(c, $urandom_range(199) == 0);
  endtask

  // Printable byte other than the one that would end the current context
  function automatic logic [7:0] printable_except(input logic [7:0] bar);
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == bar);
    return c;
  endfunction

  // One fragment of source text: mostly well-formed, some noise
  task automatic send_fragment();
    int         pick;
    int         len;
    logic [7:0] c;
    pick = $urandom_range(99);
    len  = $urandom_range(1, 6);
    if (pick < 22) begin
      repeat (len) send_text(8'($urandom_range(8'h61, 8'h7A)));
    end else if (pick < 38) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0: c = CH_SPACE;
          1: c = CH_TAB;
          2: c = CH_CR;
          default: c = CH_LF;
        endcase
        send_text(c);
      end
    end else if (pick < 50) begin
      send_text(CH_SLASH);
      send_text(CH_SLASH);
      repeat (len) send_text(printable_except(CH_SLASH));
      send_text($urandom_range(1) ? CH_CR : CH_LF);
    end else if (pick < 64) begin
      send_text(CH_SLASH);
      send_text(CH_STAR);
      repeat (len - 1)
        send_text(($urandom_range(9) < 3) ? CH_STAR : printable_except(CH_SLASH));
      repeat ($urandom_range(1, 3)) send_text(CH_STAR);
      send_text(CH_SLASH);
    end else if (pick < 74) begin
      send_text(CH_DQUOTE);
      repeat (len - 1) send_text(printable_except(CH_DQUOTE));
      send_text(CH_DQUOTE);
    end else if (pick < 82) begin
      send_text(CH_SQUOTE);
      repeat (len - 1) send_text(printable_except(CH_SQUOTE));
      send_text(CH_SQUOTE);
    end else if (pick < 90) begin
      send_text(CH_SLASH);
      send_text(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) send_text(8'($urandom_range(255)));
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cycles          = 0;
    bytes_sent      = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_left       = 0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.restart   = 1'b0;
    out_ch.ready    = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) send_byte(OPENING[i][7:0], OPENING[i][8]);

    // Random text in four idling phases; fill the block once with a long hold-off
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 84; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 84; end
        default: begin tx_idle_pct = 10; rx_stall_pct <= 10; end
      endcase
      for (int target = bytes_sent + RANDOM_ITEMS / 4; bytes_sent < target; ) begin
        if (phase == 0 && hold_left == 0 && bytes_sent > 80 && bytes_sent < 90)
          hold_left <= 300;
        send_fragment();
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow the pipeline depth to settle
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tcws_pkg.sv
rtl/tcws_channels.sv
rtl/tcws_in_reg.sv
rtl/tcws_core.sv
rtl/tcws_out_reg.sv
rtl/text_comment_whitespace_stripper.sv
verif/tb_text_comment_whitespace_stripper.sv
